// ----- rtl/hsv_to_rgb_convert_macros.svh -----
// Assertion macros used by the checker file of the colour converter.
`ifndef HSV_TO_RGB_CONVERT_MACROS_SVH
`define HSV_TO_RGB_CONVERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define HSVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define HSVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define HSVC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hsvc_pkg.sv -----
// Shared constants, types and helpers of the HSV to RGB converter.
`default_nettype none
package hsvc_pkg;

  localparam int unsigned HUE_SECTOR_DEG = 60;
  localparam int unsigned HUE_LIMIT      = 6 * HUE_SECTOR_DEG;
  localparam int unsigned HUE_PERIOD     = 2 * HUE_SECTOR_DEG;
  localparam int unsigned FULL_CODE      = 255;
  localparam int unsigned MID_DEN        = FULL_CODE * HUE_SECTOR_DEG;

  // Quotient by MID_DEN: reciprocal estimate, then one correction step.
  localparam int unsigned SPAN_W      = 22;
  localparam int unsigned RECIP_SHIFT = SPAN_W;
  localparam int unsigned RECIP_MUL   = (1 << RECIP_SHIFT) / MID_DEN;
  localparam int unsigned RECIP_W     = 9;
  localparam int unsigned REM_W       = 15;

  // Hue sector, named by the channels taking the top and middle levels.
  typedef enum logic [2:0] {
    SEC_RG   = 3'd0,
    SEC_GR   = 3'd1,
    SEC_GB   = 3'd2,
    SEC_BG   = 3'd3,
    SEC_BR   = 3'd4,
    SEC_RB   = 3'd5,
    SEC_GREY = 3'd6
  } sector_t;

  typedef struct packed {
    logic ld_est;
    logic ld_rem;
  } pipe_ctl_t;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return acc[15:8];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hsvc_quot.sv -----
// Two-stage quotient unit: ceiling of the middle-level offset over 15300.
`default_nettype none
module hsvc_quot (
  input  logic                     clk,
  input  hsvc_pkg::pipe_ctl_t      ctl,
  input  logic [hsvc_pkg::SPAN_W-1:0] span_in,
  output logic [7:0]               quot
);
  import hsvc_pkg::*;

  logic [SPAN_W-1:0]          span_r;
  logic [7:0]                 est_r;
  logic [7:0]                 est2_r;
  logic [REM_W-1:0]           rem_r;
  logic [SPAN_W+RECIP_W-1:0]  prod;
  logic [SPAN_W-1:0]          back;
  logic [SPAN_W-1:0]          rem_full;

  // The estimate never exceeds the true quotient and trails it by at most one.
  assign prod     = {{RECIP_W{1'b0}}, span_in} * (SPAN_W+RECIP_W)'(RECIP_MUL);
  assign back     = SPAN_W'(est_r) * SPAN_W'(MID_DEN);
  assign rem_full = span_r - back;

  always_ff @(posedge clk) begin
    if (ctl.ld_est) begin
      span_r <= span_in;
      est_r  <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
    end
    if (ctl.ld_rem) begin
      est2_r <= est_r;
      rem_r  <= rem_full[REM_W-1:0];
    end
  end

  assign quot = est2_r + ((rem_r >= REM_W'(MID_DEN)) ? 8'd1 : 8'd0);

endmodule
`default_nettype wire

// ----- rtl/hsv_to_rgb_convert.sv -----
// Top level of the pipelined HSV to RGB colour converter.
//
//   channel | direction | handshake           | payload
//   in_     | request   | in_valid, in_stall  | hue_degrees, saturation_frac, brightness_frac
//   out_    | result    | out_valid, out_stall| red_level, green_level, blue_level
//
// Five register stages; one request enters per clock when nothing stalls,
// and its result leaves from the fifth stage. The longest stage holds the
// 22 x 9 reciprocal multiply of the quotient unit.
// Reset (rst_n low at a clock edge) empties every stage.
// Each stage holds its request while the next one is full and stalled, so
// empty stages still take requests while a finished result waits.
`default_nettype none
module hsv_to_rgb_convert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_hue_degrees,
  input  logic [7:0]  in_saturation_frac,
  input  logic [7:0]  in_brightness_frac,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_level,
  output logic [7:0]  out_green_level,
  output logic [7:0]  out_blue_level
);
  import hsvc_pkg::*;

  // Stage valid bits, stage 1 in bit 0.
  logic [4:0]        vld_r;
  logic [4:0]        vld_nxt;
  logic [5:0]        ld;
  pipe_ctl_t         qctl;

  // Stage 1.
  sector_t           sec1_r;
  logic [5:0]        dist1_r;
  logic [15:0]       vs1_r;
  logic [15:0]       bnum1_r;
  logic [7:0]        val1_r;
  // Stage 2.
  sector_t           sec2_r;
  logic [SPAN_W-1:0] span2_r;
  logic [7:0]        bot2_r;
  logic [7:0]        val2_r;
  // Stages 3 and 4 (side band beside the quotient unit).
  sector_t           sec3_r;
  logic [7:0]        bot3_r;
  logic [7:0]        val3_r;
  sector_t           sec4_r;
  logic [7:0]        bot4_r;
  logic [7:0]        val4_r;
  // Stage 5, the output register.
  logic [7:0]        red_r;
  logic [7:0]        green_r;
  logic [7:0]        blue_r;

  logic [8:0]        hue9;
  logic [6:0]        hmod;
  logic [5:0]        hdist;
  sector_t           sec_nxt;
  logic [SPAN_W-1:0] span_nxt;
  logic [7:0]        quot;
  logic [7:0]        mid;
  logic [7:0]        red_nxt;
  logic [7:0]        green_nxt;
  logic [7:0]        blue_nxt;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    ld[5] = !out_stall;
    ld[4] = !vld_r[4] || ld[5];
    ld[3] = !vld_r[3] || ld[4];
    ld[2] = !vld_r[2] || ld[3];
    ld[1] = !vld_r[1] || ld[2];
    ld[0] = !vld_r[0] || ld[1];
  end

  always_comb begin
    vld_nxt[0] = ld[0] ? in_valid : vld_r[0];
    vld_nxt[1] = ld[1] ? vld_r[0] : vld_r[1];
    vld_nxt[2] = ld[2] ? vld_r[1] : vld_r[2];
    vld_nxt[3] = ld[3] ? vld_r[2] : vld_r[3];
    vld_nxt[4] = ld[4] ? vld_r[3] : vld_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld_r[4];

  // Stage 1: sector, distance from the nearest of 60, 180 and 300 degrees, and the two products.
  assign hue9 = in_hue_degrees[8:0];

  always_comb begin
    if (in_hue_degrees >= 16'(HUE_LIMIT)) begin
      sec_nxt = SEC_GREY;
    end else if (hue9 < 9'(HUE_SECTOR_DEG)) begin
      sec_nxt = SEC_RG;
    end else if (hue9 < 9'(2 * HUE_SECTOR_DEG)) begin
      sec_nxt = SEC_GR;
    end else if (hue9 < 9'(3 * HUE_SECTOR_DEG)) begin
      sec_nxt = SEC_GB;
    end else if (hue9 < 9'(4 * HUE_SECTOR_DEG)) begin
      sec_nxt = SEC_BG;
    end else if (hue9 < 9'(5 * HUE_SECTOR_DEG)) begin
      sec_nxt = SEC_BR;
    end else begin
      sec_nxt = SEC_RB;
    end

    if (hue9 < 9'(HUE_PERIOD)) begin
      hmod = hue9[6:0];
    end else if (hue9 < 9'(2 * HUE_PERIOD)) begin
      hmod = 7'(hue9 - 9'(HUE_PERIOD));
    end else begin
      hmod = 7'(hue9 - 9'(2 * HUE_PERIOD));
    end

    if (hmod >= 7'(HUE_SECTOR_DEG)) begin
      hdist = 6'(hmod - 7'(HUE_SECTOR_DEG));
    end else begin
      hdist = 6'(7'(HUE_SECTOR_DEG) - hmod);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sec1_r  <= sec_nxt;
      dist1_r <= hdist;
      vs1_r   <= {8'd0, in_brightness_frac} * {8'd0, in_saturation_frac};
      bnum1_r <= {8'd0, in_brightness_frac} * {8'd0, 8'(FULL_CODE) - in_saturation_frac};
      val1_r  <= in_brightness_frac;
    end
  end

  // Stage 2: offset product biased for a ceiling, and the bottom level.
  assign span_nxt = SPAN_W'(vs1_r) * SPAN_W'(dist1_r) + SPAN_W'(MID_DEN - 1);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sec2_r  <= sec1_r;
      span2_r <= span_nxt;
      bot2_r  <= div255(bnum1_r);
      val2_r  <= val1_r;
    end
  end

  // Stages 3 and 4.
  assign qctl.ld_est = ld[2];
  assign qctl.ld_rem = ld[3];

  hsvc_quot u_quot (
    .clk     (clk),
    .ctl     (qctl),
    .span_in (span2_r),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sec3_r <= sec2_r;
      bot3_r <= bot2_r;
      val3_r <= val2_r;
    end
    if (ld[3]) begin
      sec4_r <= sec3_r;
      bot4_r <= bot3_r;
      val4_r <= val3_r;
    end
  end

  // Stage 5: middle level and placement of the three levels by sector.
  assign mid = val4_r - quot;

  always_comb begin
    case (sec4_r)
      SEC_RG: begin
        red_nxt = val4_r; green_nxt = mid;    blue_nxt = bot4_r;
      end
      SEC_GR: begin
        red_nxt = mid;    green_nxt = val4_r; blue_nxt = bot4_r;
      end
      SEC_GB: begin
        red_nxt = bot4_r; green_nxt = val4_r; blue_nxt = mid;
      end
      SEC_BG: begin
        red_nxt = bot4_r; green_nxt = mid;    blue_nxt = val4_r;
      end
      SEC_BR: begin
        red_nxt = mid;    green_nxt = bot4_r; blue_nxt = val4_r;
      end
      SEC_RB: begin
        red_nxt = val4_r; green_nxt = bot4_r; blue_nxt = mid;
      end
      default: begin
        red_nxt = bot4_r; green_nxt = bot4_r; blue_nxt = bot4_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

endmodule
`default_nettype wire

// ----- rtl/hsvc_checker.sv -----
// Port-level checker for the colour converter, bound to its top level.
`default_nettype none
`include "hsv_to_rgb_convert_macros.svh"
module hsvc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_hue_degrees,
  input logic [7:0]  in_saturation_frac,
  input logic [7:0]  in_brightness_frac,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red_level,
  input logic [7:0]  out_green_level,
  input logic [7:0]  out_blue_level
);

  logic unused_in;
  assign unused_in = in_valid ^ (^in_hue_degrees) ^ (^in_saturation_frac)
                     ^ (^in_brightness_frac);

  // With the output free or empty, every stage can move, so no request waits.
  `HSVC_ASSERT_NOW(a_no_idle_stall, (!out_valid || !out_stall) && !unused_in ^ unused_in, !in_stall, "request stalled while the output could move")

  `HSVC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  `HSVC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_red_level) && $stable(out_green_level) && $stable(out_blue_level), "stalled result changed")

  `HSVC_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result shown straight after reset")

endmodule

bind hsv_to_rgb_convert hsvc_checker u_hsvc_checker (.*);
`default_nettype wire
